>>> rtl/core/tcw_pkg.sv
// Shared types and constants of the text console character writer.
// No dependencies; compiled first.
package tcw_pkg;

  // Request types
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Control characters
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // Tab stops fall on multiples of this
  localparam int TAB_STOP = 8;

  // Width of the cursor position field
  localparam int POS_BITS = 11;

  // Command kinds handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_MOVE      = 2'd1,
    CMD_READ      = 2'd2,
    CMD_READ_ZERO = 2'd3
  } cmd_kind_e;

  // Back end sequencer states
  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CLEAR = 4'b1000
  } back_state_e;

  // Input word
  typedef struct packed {
    logic                req_type;
    logic [7:0]          char_code;
    logic [7:0]          attribute;
    logic [POS_BITS-1:0] cell_index;
  } tcw_in_t;

  // Result word
  typedef struct packed {
    logic [POS_BITS-1:0] cursor_pos;
    logic [7:0]          read_char;
    logic [7:0]          read_attr;
    logic                scrolled;
  } tcw_out_t;

endpackage

>>> rtl/core/tcw_if.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on tcw_pkg.
interface tcw_in_if import tcw_pkg::*; ();
  logic    valid;
  logic    ready;
  tcw_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic     valid;
  logic     ready;
  tcw_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/text_console_char_writer_core.sv
// Top level of the text console character writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_if, tcw_front, tcw_cmd_fifo and tcw_back.
//
//   channel  dir  handshake          word
//   in_i     in   valid / ready      req_type, char_code, attribute, cell_index
//   out_o    out  valid / ready      cursor_pos, read_char, read_attr, scrolled
//
// A put or control character passes the command queue and the result register; a read
// also passes the registered store read. The back end takes one command a cycle while
// the result register drains; a read then holds it in ST_READ, a scroll in ST_CLEAR while
// one row is zeroed. After reset the store is cleared cell by cell, with in_i held not
// ready. Requests keep being taken into a two-word queue while a result waits.
module text_console_char_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic clk_i,
  input  logic rst_ni,
  tcw_in_if.sink    in_i,
  tcw_out_if.source out_o
);

  localparam int ADDR_W = $clog2(COLUMNS * ROWS);

  typedef struct packed {
    cmd_kind_e           kind;
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          char_code;
    logic [7:0]          attribute;
    logic                scroll;
    logic [POS_BITS-1:0] cursor_pos;
  } cmd_t;

  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, empty, back_ready;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .cmd_t   (cmd_t)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .back_ready_i (back_ready),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  tcw_cmd_fifo #(
    .DEPTH (2),
    .cmd_t (cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (empty)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .cmd_t   (cmd_t)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (pop_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .ready_o (back_ready),
    .out_o   (out_o)
  );

endmodule

>>> rtl/core/tcw_front.sv
// Front end: accepts requests, owns the cursor and turns each request into a command.
// Depends on tcw_pkg and tcw_in_if.
module tcw_front import tcw_pkg::*; #(
  parameter int  COLUMNS = 80,
  parameter int  ROWS    = 25,
  parameter type cmd_t   = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tcw_in_if.sink in_i,
  input  logic  back_ready_i,
  input  logic  full_i,
  output logic  push_o,
  output cmd_t  cmd_o
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int POS_W      = (ADDR_W > POS_BITS) ? ADDR_W : POS_BITS;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  tcw_in_t          req;
  logic             accept;
  logic [COL_W:0]   col_inc, col_tab;
  logic [ROW_W:0]   row_adv;
  logic             adv, scroll, in_range;
  cmd_kind_e        kind;
  logic [ADDR_W-1:0] pos_now;
  logic [POS_W-1:0]  pos_new;

  assign req      = in_i.payload;
  assign in_i.ready = back_ready_i && !full_i;
  assign accept   = in_i.valid && in_i.ready;
  assign push_o   = accept;

  // Cursor update and request classification
  always_comb begin
    col_inc  = {1'b0, col_q} + (COL_W+1)'(1);
    col_tab  = ({1'b0, col_q} | (COL_W+1)'(TAB_STOP - 1)) + (COL_W+1)'(1);
    in_range = int'(req.cell_index) < CELL_COUNT;
    col_d    = col_q;
    adv      = 1'b0;
    kind     = CMD_MOVE;
    if (req.req_type == REQ_READ) begin
      kind = in_range ? CMD_READ : CMD_READ_ZERO;
    end else begin
      unique case (req.char_code)
        CH_LF: begin
          col_d = '0;
          adv   = 1'b1;
        end
        CH_CR: begin
          col_d = '0;
        end
        CH_TAB: begin
          if (col_tab >= (COL_W+1)'(COLUMNS)) begin
            col_d = '0;
            adv   = 1'b1;
          end else begin
            col_d = col_tab[COL_W-1:0];
          end
        end
        default: begin
          kind = CMD_WRITE;
          if (col_inc >= (COL_W+1)'(COLUMNS)) begin
            col_d = '0;
            adv   = 1'b1;
          end else begin
            col_d = col_inc[COL_W-1:0];
          end
        end
      endcase
    end
    row_adv = {1'b0, row_q} + (ROW_W+1)'(adv);
    scroll  = row_adv > (ROW_W+1)'(ROWS - 1);
    row_d   = scroll ? ROW_W'(ROWS - 1) : row_adv[ROW_W-1:0];
  end

  // Linear positions: write address before the move, reported cursor after it
  assign pos_now = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign pos_new = POS_W'(row_d) * POS_W'(COLUMNS) + POS_W'(col_d);

  // Command word
  always_comb begin
    cmd_o.kind       = kind;
    cmd_o.addr       = (req.req_type == REQ_READ) ? ADDR_W'(req.cell_index) : pos_now;
    cmd_o.char_code  = req.char_code;
    cmd_o.attribute  = req.attribute;
    cmd_o.scroll     = scroll;
    cmd_o.cursor_pos = pos_new[POS_BITS-1:0];
  end

  // Cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> rtl/core/tcw_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on tcw_pkg only through the command type handed in.
module tcw_cmd_fifo #(
  parameter int  DEPTH = 2,
  parameter type cmd_t = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/tcw_back.sv
// Back end: cell store as a row ring, command sequencer, row clearing and result register.
// Depends on tcw_pkg and tcw_out_if.
module tcw_back import tcw_pkg::*; #(
  parameter int  COLUMNS = 80,
  parameter int  ROWS    = 25,
  parameter type cmd_t   = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic empty_i,
  output logic pop_o,
  output logic ready_o,
  tcw_out_if.source out_o
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Logical address to physical address: the top row sits at base_q
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] a,
                                             input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ADDR_W+1)'(CELL_COUNT)) begin
      s = s - (ADDR_W+1)'(CELL_COUNT);
    end
    return s[ADDR_W-1:0];
  endfunction

  logic [15:0]       mem_q [CELL_COUNT];
  logic [15:0]       rdata_q;
  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic              out_valid_q, out_valid_d;
  tcw_out_t          out_q;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata;

  assign ready_o       = state_q != ST_INIT;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = cnt_q;
    wdata   = '0;
    re      = 1'b0;
    raddr   = phys(cmd_i.addr, base_q);
    unique case (state_q)
      ST_INIT: begin
        // clear the whole store after reset
        we = 1'b1;
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (!empty_i && (!out_valid_q || out_o.ready)) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_WRITE: begin
              we    = 1'b1;
              waddr = phys(cmd_i.addr, base_q);
              wdata = {cmd_i.attribute, cmd_i.char_code};
              if (cmd_i.scroll) begin
                state_d = ST_CLEAR;
              end
            end
            CMD_READ: begin
              re      = 1'b1;
              state_d = ST_READ;
            end
            CMD_READ_ZERO: begin
              state_d = ST_IDLE;
            end
            default: begin
              if (cmd_i.scroll) begin
                state_d = ST_CLEAR;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        // zero the old top row, which becomes the new bottom row
        we    = 1'b1;
        waddr = base_q + cnt_q;
        if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
          cnt_d   = '0;
          base_d  = phys(base_q, ADDR_W'(COLUMNS));
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid: loads on a popped command, or when read data arrives
  always_comb begin
    out_valid_d = out_valid_q;
    if ((pop_o && cmd_i.kind != CMD_READ) || state_q == ST_READ) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Cell store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.cursor_pos <= cmd_i.cursor_pos;
      out_q.read_char  <= '0;
      out_q.read_attr  <= '0;
      out_q.scrolled   <= cmd_i.scroll;
    end else if (state_q == ST_READ) begin
      out_q.read_char <= rdata_q[7:0];
      out_q.read_attr <= rdata_q[15:8];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
